/* design/fcta_pkg.sv */
// Shared types and field widths for the FIFO control token arbiter.
// No dependencies; imported by the top level.
package fcta_pkg;

  // Field widths of the input and result words.
  localparam int CmdW       = 2;
  localparam int SlotFieldW = 4;
  localparam int StatusW    = 3;
  localparam int CountW     = 5;

  // Default number of client slots.
  localparam int SlotCountDef = 16;

  typedef enum logic [CmdW-1:0] {
    CMD_JOIN    = 2'd0,
    CMD_REQUEST = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_LEAVE   = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED        = 3'd0,
    ST_QUEUED         = 3'd1,
    ST_ALREADY_OWNER  = 3'd2,
    ST_ALREADY_QUEUED = 3'd3,
    ST_IGNORED        = 3'd4,
    ST_NO_FREE        = 3'd5,
    ST_DONE           = 3'd6
  } status_e;

endpackage

/* design/fcta_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fcta_ram #(
  parameter int Width = 4,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/fifo_control_token_arbiter_top.sv */
// Top level of the FIFO control token arbiter: command sequencer, slot flags,
// owner register and the wait queue held in fcta_ram. Depends on fcta_pkg.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  cmd_i, client_slot_i
//   out      output     out_valid_o / out_ready_i status_o, joined_slot_o,
//                                               owner_valid_o, owner_slot_o,
//                                               waiting_count_o, queue_position_o
//
// One word is processed at a time. A join or an owner leave that falls back to
// the lowest active slot scans the slot flags one per cycle; a request or a
// non-owner leave walks the queue through the registered RAM read port, one
// entry per cycle, and decides once the last entry read has been checked.
// Reset clears the slot flags, owner and queue pointers at once; queue entries
// are not cleared. A new word is taken while a finished result waits in the
// output register; a stalled output only holds the next result in its final step.
module fifo_control_token_arbiter_top #(
  parameter int SlotCount = fcta_pkg::SlotCountDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fcta_pkg::CmdW-1:0]       cmd_i,
  input  logic [fcta_pkg::SlotFieldW-1:0] client_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fcta_pkg::StatusW-1:0]    status_o,
  output logic [fcta_pkg::SlotFieldW-1:0] joined_slot_o,
  output logic                           owner_valid_o,
  output logic [fcta_pkg::SlotFieldW-1:0] owner_slot_o,
  output logic [fcta_pkg::CountW-1:0]     waiting_count_o,
  output logic [fcta_pkg::CountW-1:0]     queue_position_o
);

  import fcta_pkg::*;

  localparam int SlotW = $clog2(SlotCount);
  localparam int FillW = $clog2(SlotCount + 1);
  localparam int SumW  = SlotW + 2;
  localparam int CmpW  = ((SlotW > SlotFieldW) ? SlotW : SlotFieldW) + 1;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_FREE   = 3'd2;
  localparam logic [2:0] S_QSCAN  = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_POPD   = 3'd5;
  localparam logic [2:0] S_LOWEST = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]            state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [SlotFieldW-1:0] slot_q, slot_d;
  logic [SlotCount-1:0]  active_q, active_d;
  logic                  owner_v_q, owner_v_d;
  logic [SlotW-1:0]      owner_q, owner_d;
  logic [SlotW-1:0]      front_q, front_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic [FillW-1:0]      rk_q, rk_d;
  logic [FillW-1:0]      kept_q, kept_d;
  logic                  rvalid_q, rvalid_d;
  logic                  dup_q, dup_d;
  status_e               res_status_q, res_status_d;
  logic [SlotFieldW-1:0] res_joined_q, res_joined_d;
  logic [CountW-1:0]     res_qpos_q, res_qpos_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  status_e               out_status_q;
  logic [SlotFieldW-1:0] out_joined_q;
  logic                  out_ownv_q;
  logic [SlotFieldW-1:0] out_owner_q;
  logic [CountW-1:0]     out_count_q;
  logic [CountW-1:0]     out_qpos_q;

  logic                  ram_we, ram_re;
  logic [SlotW-1:0]      ram_waddr, ram_raddr;
  logic [SlotFieldW-1:0] ram_wdata, ram_rdata;

  logic                  owner_hit;
  logic                  slot_act;
  logic                  entry_act;

  // True when a slot number names an existing, active slot.
  function automatic logic slot_is_active(logic [SlotFieldW-1:0] s,
                                          logic [SlotCount-1:0] act);
    logic [CmpW-1:0] s_w;
    s_w = CmpW'(s);
    return (s_w < CmpW'(SlotCount)) && act[s_w[SlotW-1:0]];
  endfunction

  // Circular queue position: front plus an offset, modulo the depth.
  function automatic logic [SlotW-1:0] wrap_idx(logic [SlotW-1:0] base,
                                                logic [FillW-1:0] off);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + SumW'(off);
    if (sum >= SumW'(SlotCount)) begin
      sum = sum - SumW'(SlotCount);
    end
    return sum[SlotW-1:0];
  endfunction

  assign owner_hit = owner_v_q && (CmpW'(owner_q) == CmpW'(slot_q));
  assign slot_act  = slot_is_active(slot_q, active_q);
  assign entry_act = slot_is_active(ram_rdata, active_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  // Command sequencer: decode, slot scans, queue walk and pop.
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    active_d     = active_q;
    owner_v_d    = owner_v_q;
    owner_d      = owner_q;
    front_d      = front_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    rk_d         = rk_q;
    kept_d       = kept_q;
    rvalid_d     = 1'b0;
    dup_d        = dup_q;
    res_status_d = res_status_q;
    res_joined_d = res_joined_q;
    res_qpos_d   = res_qpos_q;
    ram_we       = 1'b0;
    ram_waddr    = wrap_idx(front_q, fill_q);
    ram_wdata    = slot_q;
    ram_re       = 1'b0;
    ram_raddr    = wrap_idx(front_q, rk_q);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_e'(cmd_i);
          slot_d  = client_slot_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_joined_d = '0;
        res_qpos_d   = '0;
        res_status_d = ST_IGNORED;
        idx_d        = '0;
        rk_d         = '0;
        kept_d       = '0;
        dup_d        = 1'b0;
        state_d      = S_FINISH;
        if (cmd_q == CMD_JOIN) begin
          state_d = S_FREE;
        end else if (slot_act) begin
          case (cmd_q)
            CMD_REQUEST: begin
              if (owner_hit) begin
                res_status_d = ST_ALREADY_OWNER;
              end else if (!owner_v_q) begin
                owner_v_d    = 1'b1;
                owner_d      = SlotW'(slot_q);
                res_status_d = ST_GRANTED;
              end else begin
                state_d = S_QSCAN;
              end
            end
            CMD_RELEASE: begin
              if (owner_hit) begin
                owner_v_d    = 1'b0;
                owner_d      = '0;
                res_status_d = ST_DONE;
                state_d      = S_POP;
              end
            end
            default: begin
              // Leave: drop the slot, then either hand on the token or
              // compact the queue.
              active_d[SlotW'(slot_q)] = 1'b0;
              res_status_d = ST_DONE;
              if (owner_hit) begin
                owner_v_d = 1'b0;
                owner_d   = '0;
                state_d   = S_POP;
              end else begin
                state_d = S_QSCAN;
              end
            end
          endcase
        end
      end

      S_FREE: begin
        // Lowest free slot, one flag per cycle.
        if (!active_q[idx_q]) begin
          active_d[idx_q] = 1'b1;
          res_joined_d    = SlotFieldW'(idx_q);
          if (!owner_v_q) begin
            owner_v_d    = 1'b1;
            owner_d      = idx_q;
            res_status_d = ST_GRANTED;
          end else begin
            res_status_d = ST_DONE;
          end
          state_d = S_FINISH;
        end else if (idx_q == SlotW'(SlotCount - 1)) begin
          res_status_d = ST_NO_FREE;
          state_d      = S_FINISH;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end

      S_QSCAN: begin
        // Issue one read per cycle; the entry read last cycle is checked now.
        if (rk_q < fill_q) begin
          ram_re   = 1'b1;
          rk_d     = rk_q + FillW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          if (cmd_q == CMD_REQUEST) begin
            if (ram_rdata == slot_q) begin
              dup_d = 1'b1;
            end
          end else if ((ram_rdata != slot_q) && entry_act) begin
            ram_we    = 1'b1;
            ram_waddr = wrap_idx(front_q, kept_q);
            ram_wdata = ram_rdata;
            kept_d    = kept_q + FillW'(1);
          end
        end
        if ((rk_q == fill_q) && !rvalid_q) begin
          state_d = S_FINISH;
          if (cmd_q == CMD_REQUEST) begin
            if (dup_q) begin
              res_status_d = ST_ALREADY_QUEUED;
            end else if (fill_q >= FillW'(SlotCount)) begin
              res_status_d = ST_IGNORED;
            end else begin
              ram_we       = 1'b1;
              fill_d       = fill_q + FillW'(1);
              res_qpos_d   = CountW'(fill_q) + CountW'(1);
              res_status_d = ST_QUEUED;
            end
          end else begin
            fill_d = kept_q;
          end
        end
      end

      S_POP: begin
        if (fill_q == '0) begin
          state_d = (cmd_q == CMD_LEAVE) ? S_LOWEST : S_FINISH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = front_q;
          front_d   = wrap_idx(front_q, FillW'(1));
          fill_d    = fill_q - FillW'(1);
          state_d   = S_POPD;
        end
      end

      S_POPD: begin
        // The dequeued head takes the token if it is still active.
        if (entry_act) begin
          owner_v_d = 1'b1;
          owner_d   = SlotW'(ram_rdata);
          state_d   = S_FINISH;
        end else begin
          state_d = (cmd_q == CMD_LEAVE) ? S_LOWEST : S_FINISH;
        end
      end

      S_LOWEST: begin
        // Owner left with no usable head: lowest active slot takes the token.
        if (active_q[idx_q]) begin
          owner_v_d = 1'b1;
          owner_d   = idx_q;
          state_d   = S_FINISH;
        end else if (idx_q == SlotW'(SlotCount - 1)) begin
          state_d = S_FINISH;
        end else begin
          idx_d = idx_q + SlotW'(1);
        end
      end

      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      owner_v_q   <= 1'b0;
      owner_q     <= '0;
      front_q     <= '0;
      fill_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      owner_v_q   <= owner_v_d;
      owner_q     <= owner_d;
      front_q     <= front_d;
      fill_q      <= fill_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    slot_q       <= slot_d;
    idx_q        <= idx_d;
    rk_q         <= rk_d;
    kept_q       <= kept_d;
    dup_q        <= dup_d;
    res_status_q <= res_status_d;
    res_joined_q <= res_joined_d;
    res_qpos_q   <= res_qpos_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_joined_q <= res_joined_q;
      out_ownv_q   <= owner_v_q;
      out_owner_q  <= owner_v_q ? SlotFieldW'(owner_q) : '0;
      out_count_q  <= CountW'(fill_q);
      out_qpos_q   <= res_qpos_q;
    end
  end

  // Wait queue storage.
  fcta_ram #(
    .Width (SlotFieldW),
    .Depth (SlotCount)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign joined_slot_o    = out_joined_q;
  assign owner_valid_o    = out_ownv_q;
  assign owner_slot_o     = out_owner_q;
  assign waiting_count_o  = out_count_q;
  assign queue_position_o = out_qpos_q;

endmodule
